// ----- sv/psp_pkg.sv -----
// ----------------------------------------------------------------------------
// psp_pkg
// shared types and constants of the perspective starfield plotter
// ----------------------------------------------------------------------------
package psp_pkg;

    // numerator of the projection: x * 128 + half screen * depth
    localparam int NUM_W = 21;
    localparam int QUO_W = 20;
    localparam int DIGIT_BITS = 4;
    localparam int DIV_STEPS = QUO_W / DIGIT_BITS;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [8:0] RESPAWN_DEPTH = 9'd256;
    localparam logic [8:0] NEAR_DEPTH = 9'd64;
    localparam logic [7:0] MAX_GRAY = 8'd255;

    typedef enum logic {
        CMD_LOAD = 1'b0,
        CMD_ADVANCE = 1'b1
    } cmd_t;

    // word passed from front to back
    typedef struct packed {
        logic live;
        logic signed [NUM_W-1:0] nx;
        logic signed [NUM_W-1:0] ny;
        logic [8:0] z;
    } job_t;

    // projected point handed to the emitter
    typedef struct packed {
        logic live;
        logic signed [NUM_W-1:0] sx;
        logic signed [NUM_W-1:0] sy;
        logic [8:0] z;
    } point_t;

endpackage

// ----- sv/psp_queue.sv -----
// ----------------------------------------------------------------------------
// psp_queue
// small job queue between front and back
// ----------------------------------------------------------------------------
module psp_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  psp_pkg::job_t  push_job,
    input  logic           pop,
    output logic           not_empty,
    output psp_pkg::job_t  head_job,
    output logic [2:0]     count
);
    import psp_pkg::*;

    job_t       slot_reg [QUEUE_DEPTH];
    logic [1:0] wr_ptr_reg;
    logic [1:0] rd_ptr_reg;
    logic [2:0] count_reg;
    logic [2:0] count_next;

    assign not_empty = (count_reg != 3'd0);
    assign head_job  = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 3'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 2'd1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 2'd1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ----- sv/psp_div.sv -----
// ----------------------------------------------------------------------------
// psp_div
// iterative unsigned divider, four quotient bits a cycle
// ----------------------------------------------------------------------------
module psp_div (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic                      ack,
    input  logic [psp_pkg::QUO_W-1:0] dividend,
    input  logic [8:0]                divisor,
    output logic [psp_pkg::QUO_W-1:0] quot,
    output logic                      idle,
    output logic                      ready
);
    import psp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } div_state_t;

    localparam logic [2:0] LAST_STEP = 3'(DIV_STEPS - 1);

    div_state_t       state_reg;
    logic [QUO_W-1:0] dvd_reg;
    logic [QUO_W-1:0] dvd_next;
    logic [8:0]       dvs_reg;
    logic [8:0]       rem_reg;
    logic [8:0]       rem_next;
    logic [QUO_W-1:0] quot_reg;
    logic [QUO_W-1:0] quot_next;
    logic [2:0]       cnt_reg;

    assign quot  = quot_reg;
    assign idle  = (state_reg == ST_IDLE);
    assign ready = (state_reg == ST_DONE);

    // four restoring steps
    always_comb
    begin
        logic [9:0] trial;
        trial     = '0;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quot_next = quot_reg;
        for (int i = 0; i < DIGIT_BITS; i++)
        begin
            trial    = {rem_next, dvd_next[QUO_W-1]};
            dvd_next = {dvd_next[QUO_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial     = trial - {1'b0, dvs_reg};
                quot_next = {quot_next[QUO_W-2:0], 1'b1};
            end
            else
            begin
                quot_next = {quot_next[QUO_W-2:0], 1'b0};
            end
            rem_next = trial[8:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dvd_reg   <= '0;
            dvs_reg   <= '0;
            rem_reg   <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else if (start)
        begin
            state_reg <= ST_RUN;
            dvd_reg   <= dividend;
            dvs_reg   <= divisor;
            rem_reg   <= '0;
            quot_reg  <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_RUN:
                begin
                    dvd_reg  <= dvd_next;
                    rem_reg  <= rem_next;
                    quot_reg <= quot_next;
                    cnt_reg  <= cnt_reg + 3'd1;
                    if (cnt_reg == LAST_STEP)
                    begin
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (ack)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

// ----- sv/psp_front.sv -----
// ----------------------------------------------------------------------------
// psp_front
// accepts items, keeps the star table and queues projection jobs
// ----------------------------------------------------------------------------
module psp_front #(
    parameter int STAR_COUNT = 512,
    parameter int SCREEN_W   = 320,
    parameter int SCREEN_H   = 240
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic                  cmd,
    input  logic [8:0]            star_index,
    input  logic signed [9:0]     pos_x,
    input  logic signed [8:0]     pos_y,
    input  logic [8:0]            load_depth,
    input  logic [7:0]            depth_step,
    input  logic [2:0]            queue_count,
    output logic                  push,
    output psp_pkg::job_t         push_job
);
    import psp_pkg::*;

    localparam int AW = (STAR_COUNT > 1) ? $clog2(STAR_COUNT) : 1;
    localparam logic [NUM_W-1:0] HALF_W = NUM_W'(SCREEN_W / 2);
    localparam logic [NUM_W-1:0] HALF_H = NUM_W'(SCREEN_H / 2);

    logic [27:0]   mem [STAR_COUNT];
    logic [27:0]   rd_reg;

    logic          accept;
    logic          s1_valid_reg;
    cmd_t          s1_cmd_reg;
    logic          s1_inr_reg;
    logic [AW-1:0] s1_addr_reg;
    logic [9:0]    s1_px_reg;
    logic [8:0]    s1_py_reg;
    logic [8:0]    s1_ld_reg;

    logic          byp_valid_reg;
    logic [AW-1:0] byp_addr_reg;
    logic [27:0]   byp_data_reg;

    logic          in_range;
    logic [27:0]   cur;
    logic signed [9:0] zd;
    logic          wr_en;
    logic [27:0]   wr_data;
    logic [9:0]    new_x;
    logic [8:0]    new_y;
    logic [8:0]    new_z;

    assign busy     = ((queue_count + 3'(s1_valid_reg)) >= 3'(QUEUE_DEPTH));
    assign accept   = start && !busy;
    assign in_range = ({23'd0, star_index} < STAR_COUNT);

    always_comb
    begin
        logic respawn;
        cur = (byp_valid_reg && (byp_addr_reg == s1_addr_reg)) ? byp_data_reg : rd_reg;
        zd  = $signed({1'b0, cur[8:0]}) - $signed({2'b00, depth_step});
        respawn = zd[9] || (zd == 10'sd0);
        if (s1_cmd_reg == CMD_LOAD)
        begin
            new_x = s1_px_reg;
            new_y = s1_py_reg;
            new_z = s1_ld_reg;
        end
        else if (respawn)
        begin
            new_x = s1_px_reg;
            new_y = s1_py_reg;
            new_z = RESPAWN_DEPTH;
        end
        else
        begin
            new_x = cur[27:18];
            new_y = cur[17:9];
            new_z = zd[8:0];
        end
        wr_data = {new_x, new_y, new_z};
        wr_en   = s1_valid_reg && s1_inr_reg;

        push          = s1_valid_reg && (s1_cmd_reg == CMD_ADVANCE);
        push_job.live = s1_inr_reg;
        push_job.z    = s1_inr_reg ? new_z : 9'd1;
        push_job.nx   = s1_inr_reg
                      ? $signed({{4{new_x[9]}}, new_x, 7'd0} + HALF_W * {12'd0, new_z})
                      : '0;
        push_job.ny   = s1_inr_reg
                      ? $signed({{5{new_y[8]}}, new_y, 7'd0} + HALF_H * {12'd0, new_z})
                      : '0;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[s1_addr_reg] <= wr_data;
        end
        if (accept)
        begin
            rd_reg <= mem[AW'(star_index)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            byp_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (wr_en)
            begin
                byp_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_t'(cmd);
            s1_inr_reg  <= in_range;
            s1_addr_reg <= AW'(star_index);
            s1_px_reg   <= pos_x;
            s1_py_reg   <= pos_y;
            s1_ld_reg   <= load_depth;
        end
        if (wr_en)
        begin
            byp_addr_reg <= s1_addr_reg;
            byp_data_reg <= wr_data;
        end
    end

endmodule

// ----- sv/psp_back.sv -----
// ----------------------------------------------------------------------------
// psp_back
// perspective divide of queued jobs, result held for the emitter
// ----------------------------------------------------------------------------
module psp_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             job_valid,
    input  psp_pkg::job_t    job,
    output logic             pop,
    output logic             point_valid,
    output psp_pkg::point_t  point,
    input  logic             take
);
    import psp_pkg::*;

    logic [QUO_W-1:0] qx;
    logic [QUO_W-1:0] qy;
    logic             x_idle;
    logic             x_ready;
    logic             y_idle;
    logic             y_ready;
    logic             ack;
    logic             free;
    logic [QUO_W-1:0] mag_x;
    logic [QUO_W-1:0] mag_y;
    logic signed [NUM_W-1:0] abs_x;
    logic signed [NUM_W-1:0] abs_y;

    logic             cur_live_reg;
    logic [8:0]       cur_z_reg;
    logic             cur_negx_reg;
    logic             cur_negy_reg;
    logic             pend_valid_reg;
    point_t           pend_reg;

    assign ack   = x_ready && y_ready && (!pend_valid_reg || take);
    assign free  = (x_idle && y_idle) || ack;
    assign pop   = job_valid && free;
    assign abs_x = job.nx[NUM_W-1] ? -job.nx : job.nx;
    assign abs_y = job.ny[NUM_W-1] ? -job.ny : job.ny;
    assign mag_x = abs_x[QUO_W-1:0];
    assign mag_y = abs_y[QUO_W-1:0];

    assign point_valid = pend_valid_reg;
    assign point       = pend_reg;

    psp_div u_div_x (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .ack      (ack),
        .dividend (mag_x),
        .divisor  (job.z),
        .quot     (qx),
        .idle     (x_idle),
        .ready    (x_ready)
    );

    psp_div u_div_y (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (pop),
        .ack      (ack),
        .dividend (mag_y),
        .divisor  (job.z),
        .quot     (qy),
        .idle     (y_idle),
        .ready    (y_ready)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (ack)
        begin
            pend_valid_reg <= 1'b1;
        end
        else if (take)
        begin
            pend_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_live_reg <= job.live;
            cur_z_reg    <= job.z;
            cur_negx_reg <= job.nx[NUM_W-1];
            cur_negy_reg <= job.ny[NUM_W-1];
        end
        if (ack)
        begin
            // truncation toward zero: divide magnitudes, restore sign
            pend_reg.live <= cur_live_reg;
            pend_reg.z    <= cur_z_reg;
            pend_reg.sx   <= cur_negx_reg ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
            pend_reg.sy   <= cur_negy_reg ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
        end
    end

endmodule

// ----- sv/psp_emit.sv -----
// ----------------------------------------------------------------------------
// psp_emit
// screen test and pixel write sequencing, one word a cycle
// ----------------------------------------------------------------------------
module psp_emit #(
    parameter int SCREEN_W = 320,
    parameter int SCREEN_H = 240
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             point_valid,
    input  psp_pkg::point_t  point,
    output logic             take,
    output logic             result_strobe,
    output logic [8:0]       pixel_x,
    output logic [7:0]       pixel_y,
    output logic [7:0]       gray_level,
    output logic             write_valid,
    output logic             last_result
);
    import psp_pkg::*;

    localparam logic signed [NUM_W-1:0] SW = NUM_W'(SCREEN_W);
    localparam logic signed [NUM_W-1:0] SH = NUM_W'(SCREEN_H);

    // mask bits: centre, left, right, up, down
    logic       em_valid_reg;
    logic [4:0] em_mask_reg;
    logic [8:0] em_sx_reg;
    logic [7:0] em_sy_reg;
    logic [7:0] em_gray_reg;
    logic       em_wv_reg;

    logic       strobe_reg;
    logic [8:0] px_reg;
    logic [7:0] py_reg;
    logic [7:0] gray_reg;
    logic       wv_reg;
    logic       last_reg;

    logic [4:0] sel;
    logic [4:0] rest;
    logic       on_screen;
    logic [4:0] load_mask;
    logic [7:0] load_gray;

    assign sel  = em_mask_reg & (~em_mask_reg + 5'd1);
    assign rest = em_mask_reg & ~sel;
    assign take = point_valid && (!em_valid_reg || (rest == 5'd0));

    assign on_screen = point.live && (point.sx >= 0) && (point.sx < SW)
                       && (point.sy >= 0) && (point.sy < SH);
    assign load_gray = point.z[8] ? 8'd0 : (MAX_GRAY - point.z[7:0]);

    always_comb
    begin
        load_mask = 5'b00001;
        if (on_screen && (point.z < NEAR_DEPTH))
        begin
            load_mask[1] = (point.sx > 0);
            load_mask[2] = (point.sx < SW - 1);
            load_mask[3] = (point.sy > 0);
            load_mask[4] = (point.sy < SH - 1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            em_valid_reg <= 1'b0;
            em_mask_reg  <= '0;
            em_sx_reg    <= '0;
            em_sy_reg    <= '0;
            em_gray_reg  <= '0;
            em_wv_reg    <= 1'b0;
            strobe_reg   <= 1'b0;
            px_reg       <= '0;
            py_reg       <= '0;
            gray_reg     <= '0;
            wv_reg       <= 1'b0;
            last_reg     <= 1'b0;
        end
        else
        begin
            strobe_reg <= em_valid_reg;
            if (em_valid_reg)
            begin
                wv_reg   <= em_wv_reg;
                gray_reg <= em_gray_reg;
                last_reg <= (rest == 5'd0);
                priority if (sel[1])
                begin
                    px_reg <= em_sx_reg - 9'd1;
                    py_reg <= em_sy_reg;
                end
                else if (sel[2])
                begin
                    px_reg <= em_sx_reg + 9'd1;
                    py_reg <= em_sy_reg;
                end
                else if (sel[3])
                begin
                    px_reg <= em_sx_reg;
                    py_reg <= em_sy_reg - 8'd1;
                end
                else if (sel[4])
                begin
                    px_reg <= em_sx_reg;
                    py_reg <= em_sy_reg + 8'd1;
                end
                else
                begin
                    px_reg <= em_sx_reg;
                    py_reg <= em_sy_reg;
                end
            end
            if (take)
            begin
                em_valid_reg <= 1'b1;
                em_mask_reg  <= load_mask;
                em_wv_reg    <= on_screen;
                em_sx_reg    <= on_screen ? point.sx[8:0] : 9'd0;
                em_sy_reg    <= on_screen ? point.sy[7:0] : 8'd0;
                em_gray_reg  <= on_screen ? load_gray : 8'd0;
            end
            else
            begin
                em_valid_reg <= em_valid_reg && (rest != 5'd0);
                em_mask_reg  <= rest;
            end
        end
    end

    assign result_strobe = strobe_reg;
    assign pixel_x       = px_reg;
    assign pixel_y       = py_reg;
    assign gray_level    = gray_reg;
    assign write_valid   = wv_reg;
    assign last_result   = last_reg;

endmodule

// ----- sv/perspective_starfield_plotter.sv -----
// ----------------------------------------------------------------------------
// perspective_starfield_plotter
// star table with perspective projection and pixel write generation
// ----------------------------------------------------------------------------
//  channel   | handshake                    | word
//  ----------+------------------------------+---------------------------------
//  item in   | start high while busy low    | cmd, star_index, pos_x, pos_y,
//            |                              | load_depth
//  config    | cfg_valid and cfg_ready      | cfg_data (depth_step)
//  result    | result_strobe, one cycle     | pixel_x, pixel_y, gray_level,
//            |                              | write_valid, last_result
//
// an advance holds the back end for five divider steps of four quotient bits
// each plus a hand-off in the done state, where the next job can be popped; the
// emitter sends one to five words, one a cycle, while the next divide runs
// a load updates the table and gives no word
// busy rises when the job queue and the front stage together hold four words
// reset clears control state; the star table is not cleared
// the receiver cannot stall: results leave on their strobe cycle
// ----------------------------------------------------------------------------
module perspective_starfield_plotter #(
    parameter int STAR_COUNT = 512,
    parameter int SCREEN_W   = 320,
    parameter int SCREEN_H   = 240
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  logic              cmd,
    input  logic [8:0]        star_index,
    input  logic signed [9:0] pos_x,
    input  logic signed [8:0] pos_y,
    input  logic [8:0]        load_depth,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data,
    output logic              result_strobe,
    output logic [8:0]        pixel_x,
    output logic [7:0]        pixel_y,
    output logic [7:0]        gray_level,
    output logic              write_valid,
    output logic              last_result
);
    import psp_pkg::*;

    // depth decrement per advance
    logic [7:0] depth_step_reg;

    // front to queue
    logic       push;
    job_t       push_job;
    logic [2:0] queue_count;

    // queue to back
    logic       job_valid;
    job_t       head_job;
    logic       pop;

    // back to emitter
    logic       point_valid;
    point_t     point;
    logic       take;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            depth_step_reg <= 8'd2;
        end
        else if (cfg_valid && cfg_ready)
        begin
            depth_step_reg <= cfg_data;
        end
    end

    // front: table read-modify-write with write bypass
    psp_front #(
        .STAR_COUNT (STAR_COUNT),
        .SCREEN_W   (SCREEN_W),
        .SCREEN_H   (SCREEN_H)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .cmd         (cmd),
        .star_index  (star_index),
        .pos_x       (pos_x),
        .pos_y       (pos_y),
        .load_depth  (load_depth),
        .depth_step  (depth_step_reg),
        .queue_count (queue_count),
        .push        (push),
        .push_job    (push_job)
    );

    // decouples the table update from the divide and emission
    psp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .pop       (pop),
        .not_empty (job_valid),
        .head_job  (head_job),
        .count     (queue_count)
    );

    // back: exact perspective divide
    psp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job         (head_job),
        .pop         (pop),
        .point_valid (point_valid),
        .point       (point),
        .take        (take)
    );

    // screen test, gray level and cross neighbours
    psp_emit #(
        .SCREEN_W (SCREEN_W),
        .SCREEN_H (SCREEN_H)
    ) u_emit (
        .clk           (clk),
        .rst_n         (rst_n),
        .point_valid   (point_valid),
        .point         (point),
        .take          (take),
        .result_strobe (result_strobe),
        .pixel_x       (pixel_x),
        .pixel_y       (pixel_y),
        .gray_level    (gray_level),
        .write_valid   (write_valid),
        .last_result   (last_result)
    );

endmodule
